>>> sv/ssps_pkg.sv
package ssps_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_PAIR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_NOCHG  = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PRE,
    ST_WALK,
    ST_REST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic a_left;
    logic a_right;
    logic load_b;
    logic b_left;
  } cell_ctrl_t;

endpackage

>>> sv/ssps_cell.sv
module ssps_cell import ssps_pkg::*; (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic signed [31:0] a_right_i,
  input  logic signed [31:0] a_left_i,
  input  logic signed [31:0] b_right_i,
  output logic signed [31:0] a_o,
  output logic signed [31:0] b_o
);

  logic signed [31:0] a_q, a_d;
  logic signed [31:0] b_q, b_d;

  always_comb begin
    a_d = a_q;
    if (ctrl_i.a_left) begin
      a_d = a_right_i;
    end else if (ctrl_i.a_right) begin
      a_d = a_left_i;
    end
    b_d = b_q;
    if (ctrl_i.load_b) begin
      b_d = a_q;
    end else if (ctrl_i.b_left) begin
      b_d = b_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

>>> sv/sorted_set_with_pair_sum_core.sv
// Sorted set of distinct signed 32-bit keys held in a ring of CAPACITY cells, smallest key at
// cell 0. Insert, delete and search rotate the ring once around, one cell per cycle, rewriting
// the key stream at the tail. The pair query copies the ring into a second chain that rotates
// left for the low pointer while the main ring rotates right for the high pointer; with fewer
// than two keys held it goes straight to the result. One item is in work at a time; a new item
// is accepted while the previous result still waits in the output register.
module sorted_set_with_pair_sum_core import ssps_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic signed [31:0] first_value_o,
  output logic signed [31:0] second_value_o,
  output logic [1:0]         status_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_C = IW'(CAPACITY - 1);

  logic signed [31:0] a_w [CAPACITY];
  logic signed [31:0] b_w [CAPACITY];
  logic signed [31:0] tail_feed;
  cell_ctrl_t         ctrl;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] a_right, a_left, b_right;
    if (i == CAPACITY - 1) begin : g_last
      assign a_right = tail_feed;
      assign b_right = b_w[0];
    end else begin : g_mid
      assign a_right = a_w[i+1];
      assign b_right = b_w[i+1];
    end
    if (i == 0) begin : g_first
      assign a_left = a_w[CAPACITY-1];
    end else begin : g_rest
      assign a_left = a_w[i-1];
    end
    ssps_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .a_right_i (a_right),
      .a_left_i  (a_left),
      .b_right_i (b_right),
      .a_o       (a_w[i]),
      .b_o       (b_w[i])
    );
  end

  state_e             state_q, state_d;
  kind_e              op_q, op_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] r_q, r_d;
  logic               rv_q, rv_d;
  logic               hit_q, hit_d;
  logic               del_q, del_d;
  logic [IW-1:0]      t_q, t_d;
  logic [IW-1:0]      lo_q, lo_d;
  logic [IW-1:0]      hi_q, hi_d;
  logic [CW-1:0]      rot_q, rot_d;
  logic [CW-1:0]      count_q, count_d;
  logic               pf_q, pf_d;
  logic signed [31:0] pfirst_q, pfirst_d;
  logic signed [31:0] psecond_q, psecond_d;

  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;
  logic signed [31:0] first_q, first_d;
  logic signed [31:0] second_q, second_d;
  status_e            status_q, status_d;

  logic signed [31:0] head, next_key, hi_key, lo_key;
  logic               inrange, at_count, match, del_now;
  logic [CW-1:0]      cnt_m1, pre_target;
  logic signed [32:0] pair_sum, target;

  assign head     = a_w[0];
  assign next_key = a_w[1];
  assign hi_key   = a_w[CAPACITY-1];
  assign lo_key   = b_w[0];
  assign inrange  = CW'(t_q) < count_q;
  assign at_count = CW'(t_q) == count_q;
  assign match    = inrange && (head == key_q);
  assign del_now  = del_q | match;
  assign cnt_m1   = count_q - CW'(1);
  assign pre_target = CAP_C - count_q;
  assign pair_sum = {lo_key[31], lo_key} + {hi_key[31], hi_key};
  assign target   = {key_q[31], key_q};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    r_d         = r_q;
    rv_d        = rv_q;
    hit_d       = hit_q;
    del_d       = del_q;
    t_d         = t_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    rot_d       = rot_q;
    count_d     = count_q;
    pf_d        = pf_q;
    pfirst_d    = pfirst_q;
    psecond_d   = psecond_q;
    out_valid_d = out_valid_q & out_stall_i;
    found_d     = found_q;
    first_d     = first_q;
    second_d    = second_q;
    status_d    = status_q;
    ctrl        = '0;
    tail_feed   = head;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = kind_e'(kind_i);
          key_d     = key_i;
          r_d       = key_i;
          rv_d      = count_q != CAP_C;
          hit_d     = 1'b0;
          del_d     = 1'b0;
          t_d       = '0;
          lo_d      = '0;
          hi_d      = cnt_m1[IW-1:0];
          rot_d     = '0;
          pf_d      = 1'b0;
          pfirst_d  = '0;
          psecond_d = '0;
          if (kind_e'(kind_i) == KIND_PAIR) begin
            ctrl.load_b = 1'b1;
            state_d     = (count_q >= CW'(2)) ? ST_PRE : ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctrl.a_left = 1'b1;
        hit_d       = hit_q | match;
        case (op_q)
          KIND_INSERT: begin
            if (inrange) begin
              if (rv_q && head == r_q) begin
                rv_d = 1'b0;
              end else if (rv_q && head > r_q) begin
                tail_feed = r_q;
                r_d       = head;
              end
            end else if (at_count && rv_q) begin
              tail_feed = r_q;
              rv_d      = 1'b0;
            end
          end
          KIND_DELETE: begin
            del_d     = del_now;
            tail_feed = del_now ? next_key : head;
          end
          default: begin
            tail_feed = head;
          end
        endcase
        t_d = t_q + IW'(1);
        if (t_q == LAST_C) begin
          state_d = ST_DONE;
        end
      end
      ST_PRE: begin
        if (rot_q == pre_target) begin
          state_d = ST_WALK;
        end else begin
          ctrl.a_right = 1'b1;
          rot_d        = rot_q + CW'(1);
        end
      end
      ST_WALK: begin
        if (lo_q < hi_q) begin
          if (pair_sum == target) begin
            pf_d      = 1'b1;
            pfirst_d  = lo_key;
            psecond_d = hi_key;
            state_d   = ST_REST;
          end else if (pair_sum > target) begin
            ctrl.a_right = 1'b1;
            rot_d        = rot_q + CW'(1);
            hi_d         = hi_q - IW'(1);
          end else begin
            ctrl.b_left = 1'b1;
            lo_d        = lo_q + IW'(1);
          end
        end else begin
          state_d = ST_REST;
        end
      end
      ST_REST: begin
        if (rot_q == CAP_C) begin
          state_d = ST_DONE;
        end else begin
          ctrl.a_right = 1'b1;
          rot_d        = rot_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          first_d     = '0;
          second_d    = '0;
          status_d    = STATUS_DONE;
          unique case (op_q)
            KIND_INSERT: begin
              if (hit_q) begin
                status_d = STATUS_NOCHG;
              end else if (count_q == CAP_C) begin
                status_d = STATUS_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            KIND_DELETE: begin
              if (hit_q) begin
                count_d = cnt_m1;
              end else begin
                status_d = STATUS_NOCHG;
              end
            end
            KIND_SEARCH: begin
              found_d = hit_q;
            end
            KIND_PAIR: begin
              found_d  = pf_q;
              first_d  = pfirst_q;
              second_d = psecond_q;
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    r_q       <= r_d;
    rv_q      <= rv_d;
    hit_q     <= hit_d;
    del_q     <= del_d;
    t_q       <= t_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    rot_q     <= rot_d;
    pf_q      <= pf_d;
    pfirst_q  <= pfirst_d;
    psecond_q <= psecond_d;
    found_q   <= found_d;
    first_q   <= first_d;
    second_q  <= second_d;
    status_q  <= status_d;
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign first_value_o  = first_q;
  assign second_value_o = second_q;
  assign status_o       = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("key count above capacity");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done state");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> lo_q <= hi_q)
    else $error("pair pointers crossed");

  a_rotation_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRE || state_q == ST_WALK || state_q == ST_REST) |-> rot_q <= CAP_C)
    else $error("ring rotated past a full turn");

endmodule
